@@ design/assert_macros.svh @@
// Assertion macros included by the top level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ftps_pkg.sv @@
// Shared widths and register codes for the fat tree port select block.
`default_nettype none

package ftps_pkg;

   localparam int ID_W       = 6;   // switch id and processor id width
   localparam int PORT_W     = 3;   // output port width
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register word index, taken from paddr[2]
   localparam logic CSR_IDX_SWITCH_ID = 1'b0;

endpackage

`default_nettype wire

@@ design/ftps_req_if.sv @@
// Request channel: destination processor id with valid/ready.
`default_nettype none

interface ftps_req_if;
   logic                        valid;
   logic                        ready;
   logic [ftps_pkg::ID_W-1:0]   dst_proc_id;

   modport source (output valid, output dst_proc_id, input ready);
   modport sink   (input valid, input dst_proc_id, output ready);
endinterface

`default_nettype wire

@@ design/ftps_rsp_if.sv @@
// Response channel: selected output port and direction with valid/ready.
`default_nettype none

interface ftps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ftps_pkg::PORT_W-1:0] out_port;
   logic                        going_up;

   modport source (output valid, output out_port, output going_up, input ready);
   modport sink   (input valid, input out_port, input going_up, output ready);
endinterface

`default_nettype wire

@@ design/fat_tree_route_port_select.sv @@
// Top level: fat tree switch output port selection, three-stage pipeline.
`default_nettype none
`include "assert_macros.svh"

// Picks the output port of one fat tree switch for each destination processor id.
// The switch id is written over the APB port (register 0, byte address 0, 6 bits,
// reset 0); its level, base-(PORTS/2) digits and compare mask are decoded from the
// write data and held in registers, so the datapath never divides. Each request
// transaction gives exactly one response transaction. The stages are digit
// lookup, digit compare and port select, and ancestor reduce and port add. A new
// transaction can enter every cycle while a stage is free or the response is taken;
// the throughput is then one per cycle. Each stage holds its item while the stage
// after it is full and cannot pass its item on, so a stalled response only backs up
// the pipeline once all three stages hold work, and empty stages fill in behind it.
// Write the switch id only while no transaction is in flight.
module fat_tree_route_port_select #(
   parameter int PORTS        = 8,
   parameter int LEVELS       = 3,
   parameter int SW_PER_LEVEL = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ftps_req_if.sink                               req_ch,
   ftps_rsp_if.source                             rsp_ch,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ftps_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [ftps_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [ftps_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   localparam int ID_W     = ftps_pkg::ID_W;
   localparam int PORT_W   = ftps_pkg::PORT_W;
   localparam int ID_RANGE = 2 ** ID_W;
   localparam int HALF     = PORTS / 2;
   localparam int NCMP     = LEVELS - 1;        // digit compares per item
   localparam int LVL_W    = $clog2(LEVELS);

   // ---------------------------------------------------------------------
   // Constant decode tables, built at elaboration over every 6-bit id.
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]  dst_dig_tab [ID_RANGE][LEVELS];
   logic [ID_W-1:0]  sw_dig_tab  [ID_RANGE][NCMP];
   logic [NCMP-1:0]  mask_tab    [ID_RANGE];
   logic [LVL_W-1:0] lvl_tab     [ID_RANGE];

   for (genvar v = 0; v < ID_RANGE; v++) begin : g_tab
      localparam int LRAW = v / SW_PER_LEVEL;
      localparam int LV   = (LRAW > LEVELS - 1) ? LEVELS - 1 : LRAW;
      // below the top level digits come from the offset within the level
      localparam int OFS  = (LV < LEVELS - 1) ? v - LV * SW_PER_LEVEL : v;

      assign lvl_tab[v] = LVL_W'(LV);

      for (genvar i = 0; i < LEVELS; i++) begin : g_dst
         localparam int P = HALF ** i;
         // most significant digit keeps the whole quotient
         localparam int D = (i < LEVELS - 1) ? (v / P) % HALF : v / P;
         assign dst_dig_tab[v][i] = ID_W'(D);
      end

      for (genvar i = 0; i < NCMP; i++) begin : g_sw
         localparam int P = HALF ** i;
         // non-top switches keep the remaining quotient in their last digit
         localparam int D = (LV < LEVELS - 1 && i == LEVELS - 2) ? OFS / P
                                                                 : (OFS / P) % HALF;
         assign sw_dig_tab[v][i] = ID_W'(D);
         assign mask_tab[v][i]   = (i >= LV);
      end
   end

   // ---------------------------------------------------------------------
   // APB register: switch id plus its decoded form
   // ---------------------------------------------------------------------
   logic            csr_wr;
   logic [ID_W-1:0] wr_id;
   logic [ID_W-1:0] switch_id_ff;
   logic [ID_W-1:0] switch_id_in;
   logic [LVL_W-1:0] sw_lvl_ff, sw_lvl_in;
   logic [NCMP-1:0]  sw_mask_ff, sw_mask_in;
   logic [ID_W-1:0]  sw_dig_ff [NCMP];
   logic [ID_W-1:0]  sw_dig_in [NCMP];

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == ftps_pkg::CSR_IDX_SWITCH_ID);
   assign wr_id  = pwdata[ID_W-1:0];

   always_comb begin
      switch_id_in = switch_id_ff;
      sw_lvl_in    = sw_lvl_ff;
      sw_mask_in   = sw_mask_ff;
      sw_dig_in    = sw_dig_ff;
      if (reset) begin
         switch_id_in = '0;
         sw_lvl_in    = lvl_tab[0];
         sw_mask_in   = mask_tab[0];
         sw_dig_in    = sw_dig_tab[0];
      end else if (csr_wr) begin
         switch_id_in = wr_id;
         sw_lvl_in    = lvl_tab[wr_id];
         sw_mask_in   = mask_tab[wr_id];
         sw_dig_in    = sw_dig_tab[wr_id];
      end
   end

   always_ff @(posedge clock) begin
      switch_id_ff <= switch_id_in;
      sw_lvl_ff    <= sw_lvl_in;
      sw_mask_ff   <= sw_mask_in;
      sw_dig_ff    <= sw_dig_in;
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == ftps_pkg::CSR_IDX_SWITCH_ID) begin
         prdata = ftps_pkg::CSR_DATA_W'(switch_id_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or drains
   // ---------------------------------------------------------------------
   logic va_ff, vb_ff, vc_ff;
   logic va_in, vb_in, vc_in;
   logic en_a, en_b, en_c;

   assign en_c         = !vc_ff || rsp_ch.ready;
   assign en_b         = !vb_ff || en_c;
   assign en_a         = !va_ff || en_b;
   assign req_ch.ready = en_a;

   always_comb begin
      va_in = va_ff;
      vb_in = vb_ff;
      vc_in = vc_ff;
      if (reset) begin
         va_in = 1'b0;
         vb_in = 1'b0;
         vc_in = 1'b0;
      end else begin
         if (en_a) va_in = req_ch.valid;
         if (en_b) vb_in = va_ff;
         if (en_c) vc_in = vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      va_ff <= va_in;
      vb_ff <= vb_in;
      vc_ff <= vc_in;
   end

   // ---------------------------------------------------------------------
   // Stage A: split destination id into digits
   // ---------------------------------------------------------------------
   logic [ID_W-1:0] dig_ff [LEVELS];
   logic [ID_W-1:0] dig_in [LEVELS];

   always_comb begin
      dig_in = dig_ff;
      if (en_a && req_ch.valid) begin
         dig_in = dst_dig_tab[req_ch.dst_proc_id];
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
   end

   // ---------------------------------------------------------------------
   // Stage B: compare switch digits against higher destination digits,
   // pick the digit at the switch level
   // ---------------------------------------------------------------------
   logic [NCMP-1:0]   ok_ff, ok_in;
   logic [PORT_W-1:0] dsel_ff, dsel_in;
   logic [NCMP-1:0]   ok_now;

   always_comb begin
      for (int i = 0; i < NCMP; i++) begin
         // compares below the switch level do not count
         ok_now[i] = (sw_dig_ff[i] == dig_ff[i + 1]) || !sw_mask_ff[i];
      end
   end

   always_comb begin
      ok_in   = ok_ff;
      dsel_in = dsel_ff;
      if (en_b && va_ff) begin
         ok_in   = ok_now;
         dsel_in = dig_ff[sw_lvl_ff][PORT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      dsel_ff <= dsel_in;
   end

   // ---------------------------------------------------------------------
   // Stage C: ancestor test and port; non-ancestors go up by HALF
   // ---------------------------------------------------------------------
   logic [PORT_W-1:0] out_port_ff, out_port_in;
   logic              going_up_ff, going_up_in;
   logic              anc;

   assign anc = &ok_ff;

   always_comb begin
      out_port_in = out_port_ff;
      going_up_in = going_up_ff;
      if (en_c && vb_ff) begin
         out_port_in = anc ? dsel_ff : dsel_ff + PORT_W'(HALF);
         going_up_in = !anc;
      end
   end

   always_ff @(posedge clock) begin
      out_port_ff <= out_port_in;
      going_up_ff <= going_up_in;
   end

   assign rsp_ch.valid    = vc_ff;
   assign rsp_ch.out_port = out_port_ff;
   assign rsp_ch.going_up = going_up_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_SAME(a_ready_full, !req_ch.ready, va_ff && vb_ff && vc_ff && !rsp_ch.ready, "request stalled with a free stage")
   `ASSERT_NEXT(a_hold_b, vb_ff && vc_ff && !rsp_ch.ready, vb_ff && $stable(dsel_ff) && $stable(ok_ff), "stage B lost or changed a stalled transaction")
   `ASSERT_NEXT(a_b_to_c, vb_ff && en_c, vc_ff, "transaction dropped between stage B and output")
   `ASSERT_SAME(a_top_down, sw_lvl_ff == LVL_W'(LEVELS - 1), sw_mask_ff == '0, "top level switch has active digit compares")

endmodule

`default_nettype wire

@@ tb/sv/ftps_route_checker.sv @@
// Checker for the fat tree port select block: predicts each route and compares responses.
`default_nettype none

module ftps_route_checker #(
   parameter int PORTS        = 8,
   parameter int LEVELS       = 3,
   parameter int SW_PER_LEVEL = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ftps_req_if                                    req_mon,
   ftps_rsp_if                                    rsp_mon,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ftps_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [ftps_pkg::CSR_DATA_W-1:0]   pwdata,
   input  wire logic                              pready,
   output int                                     mismatch_count,
   output int                                     routes_pending
);

   localparam int ID_W   = ftps_pkg::ID_W;
   localparam int PORT_W = ftps_pkg::PORT_W;
   localparam int HALF   = PORTS / 2;

   typedef struct {
      logic [ID_W-1:0]   dst;
      logic [ID_W-1:0]   sw_id;
      logic [PORT_W-1:0] out_port;
      logic              going_up;
   } route_type;

   route_type       expected_routes [$];
   logic [ID_W-1:0] switch_id;

   function automatic route_type predict_route(input logic [ID_W-1:0] sw_id,
                                               input logic [ID_W-1:0] dst);
      int unsigned lvl, rem, port;
      int unsigned sw_dig  [LEVELS];
      int unsigned dst_dig [LEVELS];
      bit          ancestor;
      route_type   r;
      ancestor = 1'b1;
      lvl = sw_id / SW_PER_LEVEL;
      if (lvl > LEVELS - 1) lvl = LEVELS - 1;
      foreach (sw_dig[i]) sw_dig[i] = 0;
      if (lvl < LEVELS - 1) begin
         // below the top: offset within the level, top digit keeps the quotient
         rem = sw_id - lvl * SW_PER_LEVEL;
         for (int i = 0; i < LEVELS - 2; i++) begin
            sw_dig[i] = rem % HALF;
            rem = rem / HALF;
         end
         sw_dig[LEVELS-2] = rem;
      end else begin
         // top level: digits of the raw id, leftover quotient dropped
         rem = sw_id;
         for (int i = 0; i < LEVELS - 1; i++) begin
            sw_dig[i] = rem % HALF;
            rem = rem / HALF;
         end
      end
      rem = dst;
      for (int i = 0; i < LEVELS - 1; i++) begin
         dst_dig[i] = rem % HALF;
         rem = rem / HALF;
      end
      dst_dig[LEVELS-1] = rem;
      for (int i = lvl; i < LEVELS - 1; i++) begin
         if (sw_dig[i] != dst_dig[i+1]) ancestor = 1'b0;
      end
      port = dst_dig[lvl] + (ancestor ? 0 : HALF);
      r.dst      = dst;
      r.sw_id    = sw_id;
      r.out_port = port[PORT_W-1:0];
      r.going_up = !ancestor;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      route_type want;
      if (reset) begin
         switch_id = '0;
         expected_routes.delete();
      end else begin
         // responses first: a request taken this edge cannot answer here
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_routes.size() == 0) begin
               report_mismatch($sformatf("response port %0d up %0b with nothing outstanding",
                                         rsp_mon.out_port, rsp_mon.going_up));
            end else begin
               want = expected_routes.pop_front();
               if (rsp_mon.out_port !== want.out_port)
                  report_mismatch($sformatf("switch %0d dst %0d: out_port %0d, want %0d",
                                            want.sw_id, want.dst, rsp_mon.out_port,
                                            want.out_port));
               if (rsp_mon.going_up !== want.going_up)
                  report_mismatch($sformatf("switch %0d dst %0d: going_up %0b, want %0b",
                                            want.sw_id, want.dst, rsp_mon.going_up,
                                            want.going_up));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_routes.push_back(predict_route(switch_id, req_mon.dst_proc_id));
         if (psel && penable && pwrite && pready &&
             paddr[2] == ftps_pkg::CSR_IDX_SWITCH_ID)
            switch_id = pwdata[ID_W-1:0];
      end
      routes_pending = expected_routes.size();
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_fat_tree_route_port_select.sv @@
// Testbench top for the fat tree port select block: stimulus, register writes, verdict.
`default_nettype none

module tb_fat_tree_route_port_select;

   localparam int ID_W        = ftps_pkg::ID_W;
   localparam int CSR_ADDR_W  = ftps_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W  = ftps_pkg::CSR_DATA_W;
   localparam int UPPER_W     = CSR_DATA_W - ID_W;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 125;
   localparam int LONG_STALL  = 60;   // receiver hold-off, cycles
   localparam int SETTLE      = 8;    // pipeline is three deep

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int routes_pending;

   // quiet: no idling on either side; stall_request: one long receiver hold-off
   bit quiet         = 1'b0;
   bit stall_request = 1'b0;
   bit stall_done    = 1'b0;

   logic [ID_W-1:0] cur_switch;

   ftps_req_if req_ch ();
   ftps_rsp_if rsp_ch ();

   fat_tree_route_port_select dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ftps_route_checker route_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .routes_pending (routes_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Response side: random ready bursts, one long hold-off on request, none when quiet.
   initial begin : rsp_drive
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request && !stall_done) begin
            // long hold-off: the three stages fill and the request side backs up
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
            stall_done = 1'b1;
         end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // One request transaction; entered and left at a falling edge.
   task automatic send_dest(input logic [ID_W-1:0] dst);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.dst_proc_id <= dst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and let every outstanding transaction come back.
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (routes_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // APB write of the switch id: setup then access; upper data bits are don't-care.
   task automatic write_switch_id(input logic [ID_W-1:0] id);
      logic [UPPER_W-1:0] upper;
      upper   = ($urandom_range(0, 1) == 1) ? UPPER_W'($urandom()) : '0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {ftps_pkg::CSR_IDX_SWITCH_ID, 2'b00};
      pwdata  <= {upper, id};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_switch = id;
   endtask

   // Half the random destinations copy the switch's low id bits into the upper
   // destination digits, so levels 0 and 1 see their ancestor case often.
   function automatic logic [ID_W-1:0] pick_dest(input logic [ID_W-1:0] sw);
      logic [ID_W-1:0] d;
      d = ID_W'($urandom());
      if ($urandom_range(0, 1) == 1) d = {sw[3:0], d[1:0]};
      return d;
   endfunction

   initial begin : stimulus
      logic [ID_W-1:0] phase_id [NUM_PHASES];
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.dst_proc_id = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      cur_switch         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part.
      // Reset id 0: level 0, digits zero. Lowest and highest destinations,
      // an ancestor hit and a miss.
      send_dest(6'd0);
      send_dest(6'd63);
      send_dest(6'd3);
      send_dest(6'd4);
      drain();
      // Level 1, offset 5: ancestor only when the top destination digit is 1.
      write_switch_id(6'd21);
      send_dest(6'd20);
      send_dest(6'd23);
      send_dest(6'd0);
      send_dest(6'd47);
      drain();
      // Last level-0 switch: digits 3,3; 63, 60 and 62 all route down, 63 to port 3.
      write_switch_id(6'd15);
      send_dest(6'd63);
      send_dest(6'd60);
      send_dest(6'd62);
      drain();
      // Top level: always an ancestor, routes down.
      write_switch_id(6'd47);
      send_dest(6'd0);
      send_dest(6'd63);
      drain();
      // Id beyond the last level: level clamps to the top.
      write_switch_id(6'd63);
      send_dest(6'd5);
      send_dest(6'd42);
      drain();
      write_switch_id(6'd32);
      send_dest(6'd17);
      drain();

      // Random part: level boundaries and extremes, then random ids.
      phase_id = '{6'd0, 6'd16, 6'd31, 6'd48, 6'd15, 6'd63, 6'd32,
                   6'd47, 6'd0, 6'd0};
      phase_id[8] = ID_W'($urandom());
      phase_id[9] = ID_W'($urandom_range(0, 47));
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_switch_id(phase_id[p]);
         if (p == 1) stall_request = 1'b1;
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_dest(pick_dest(cur_switch));
         drain();
      end

      if (mismatch_count == 0 && routes_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/ftps_pkg.sv
design/ftps_req_if.sv
design/ftps_rsp_if.sv
design/fat_tree_route_port_select.sv
tb/sv/ftps_route_checker.sv
tb/sv/tb_fat_tree_route_port_select.sv
